FILE: rtl/ktai_pkg.sv
// Shared types, constants and value conversion for the keyed table with automatic key.
package ktai_pkg;

	localparam int CAPACITY   = 64;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [31:0]      KEY_ONES = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		FN_INS_KEY  = 2'd0,
		FN_INS_AUTO = 2'd1,
		FN_REMOVE   = 2'd2,
		FN_LOOKUP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_USED    = 3'd1,
		STAT_MISSING = 3'd2,
		STAT_FULL    = 3'd3,
		STAT_INVALID = 3'd4
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] key;
		logic [31:0] value;
	} op_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] key_out;
		logic [31:0] value_out;
		logic [6:0]  entry_total;
		logic [31:0] next_auto_key;
	} res_t;

	// Narrow or zero-extend a 32-bit value to the stored width.
	function automatic logic [VALUE_BITS-1:0] to_store(input logic [31:0] v);
		logic [VALUE_BITS-1:0] r;
		for (int i = 0; i < VALUE_BITS; i++) begin
			r[i] = (i < 32) ? v[i % 32] : 1'b0;
		end
		return r;
	endfunction

	// Bring a stored value back to 32 bits.
	function automatic logic [31:0] from_store(input logic [VALUE_BITS-1:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = (i < VALUE_BITS) ? v[i % VALUE_BITS] : 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: rtl/keyed_table_with_auto_id_unit.sv
// Top level of the keyed table with automatic key: stream ports, RAMs, engine, result register.
// The table holds up to 64 entries of a 32-bit key and a value, kept in insertion order in two
// RAMs with a registered read (keys and values) that share one address for writes and one for
// reads. One operation is taken at a time. Every operation with a valid key first scans the
// held keys, one RAM read per cycle. A lookup that misses, or an operation rejected after a
// scan of the whole table, goes to the response state when the scan ends, and its result is
// loaded into the output register; the next transaction can be accepted once the engine is
// back in idle. A successful insert then walks the automatic key upward with one further full
// scan per candidate, and a remove moves each later entry down one place at one entry per
// cycle. A finished result sits in an output register, so the next transaction can be
// accepted while the previous result still waits for the consumer. There is no clearing pass
// after reset: only entries below the current count are ever read.
module keyed_table_with_auto_id_unit import ktai_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // key [31:0], value [63:32]
	input  logic [1:0]   s_axis_tuser,  // func [1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,  // key_out [31:0], value_out [63:32],
	                                    // entry_total [70:64], next_auto_key [102:71], zero [103]
	output logic [2:0]   m_axis_tuser   // status [2:0]
);

	op_t                   op;
	res_t                  res;
	res_t                  out_q;
	logic                  out_valid_q;
	logic                  eng_idle;
	logic                  res_valid;
	logic                  res_ready;
	logic                  start;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [IDX_W-1:0]      mem_raddr;
	logic [31:0]           key_wdata;
	logic [VALUE_BITS-1:0] val_wdata;
	logic [31:0]           key_rdata;
	logic [VALUE_BITS-1:0] val_rdata;

	// Unpack the input transaction.
	always_comb begin
		op.func  = func_t'(s_axis_tuser);
		op.key   = s_axis_tdata[31:0];
		op.value = s_axis_tdata[63:32];
	end

	assign s_axis_tready = eng_idle;
	assign start         = s_axis_tvalid && s_axis_tready;

	// The result register frees up when empty or when its content is taken this cycle.
	assign res_ready = !out_valid_q || m_axis_tready;

	ktai_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_key_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (key_wdata),
		.raddr (mem_raddr),
		.rdata (key_rdata)
	);

	ktai_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_val_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (val_wdata),
		.raddr (mem_raddr),
		.rdata (val_rdata)
	);

	ktai_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_raddr (mem_raddr),
		.key_wdata (key_wdata),
		.val_wdata (val_wdata),
		.key_rdata (key_rdata),
		.val_rdata (val_rdata)
	);

	// Hold the result until the consumer takes it; load a new one when the slot frees.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {1'b0, out_q.next_auto_key, out_q.entry_total, out_q.value_out,
		out_q.key_out};

`ifndef NO_ASSERTIONS
	// One operation at a time: an accepted transaction makes the engine busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an operation is in progress");

	// A result that the register cannot take stays offered by the engine.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("engine dropped a result that was not taken");

	// The engine never offers a result while it is also taking a new operation.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("engine idle while a result is pending");

	// The automatic key is never zero on a delivered result.
	a_next_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[102:71] != 32'd0))
		else $error("next automatic key is zero");
`endif

endmodule

FILE: rtl/ktai_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ktai_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/ktai_engine.sv
// Sequencer that scans, inserts, removes and advances the automatic key over the two RAMs.
module ktai_engine import ktai_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  op_t                   op,
	output logic                  idle,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output logic [IDX_W-1:0]      mem_raddr,
	output logic [31:0]           key_wdata,
	output logic [VALUE_BITS-1:0] val_wdata,
	input  logic [31:0]           key_rdata,
	input  logic [VALUE_BITS-1:0] val_rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_ADV,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t           state_q;
	func_t            func_q;
	logic [31:0]      key_q;
	logic [31:0]      val_q;
	logic [31:0]      target_q;
	logic             adv_q;
	logic [CNT_W-1:0] addr_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      next_id_q;
	status_t          status_q;
	logic [31:0]      vout_q;

	logic             is_insert;
	logic             key_match;
	logic             scan_miss;
	logic             issue;
	logic             ins_write;
	logic [CNT_W-1:0] addr_dec;

	assign is_insert = (func_q == FN_INS_KEY) || (func_q == FN_INS_AUTO);
	assign key_match = pend_s1 && (key_rdata == target_q);
	assign issue     = addr_q < count_q;
	assign scan_miss = !pend_s1 && !issue;
	assign ins_write = (state_q == S_SCAN) && !key_match && scan_miss && !adv_q && is_insert
		&& (count_q < CAP_CNT);
	assign addr_dec  = addr_q - CNT_W'(1);

	// Write the new entry at the tail, or move an entry down one place during removal.
	assign mem_we    = ins_write || ((state_q == S_SHIFT) && pend_s1);
	assign mem_waddr = (state_q == S_SHIFT) ? pidx_s1 : count_q[IDX_W-1:0];
	assign mem_raddr = addr_q[IDX_W-1:0];
	assign key_wdata = (state_q == S_SHIFT) ? key_rdata : key_q;
	assign val_wdata = (state_q == S_SHIFT) ? val_rdata : to_store(val_q);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);

	always_comb begin
		res.status        = status_q;
		res.key_out       = key_q;
		res.value_out     = vout_q;
		res.entry_total   = 7'(count_q);
		res.next_auto_key = next_id_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			func_q    <= FN_INS_KEY;
			key_q     <= '0;
			val_q     <= '0;
			target_q  <= '0;
			adv_q     <= 1'b0;
			addr_q    <= '0;
			pend_s1   <= 1'b0;
			pidx_s1   <= '0;
			count_q   <= '0;
			next_id_q <= 32'd1;
			status_q  <= STAT_OK;
			vout_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						func_q  <= op.func;
						key_q   <= (op.func == FN_INS_AUTO) ? next_id_q : op.key;
						val_q   <= op.value;
						vout_q  <= '0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (key_q == '0 || key_q == KEY_ONES) begin
						status_q <= STAT_INVALID;
						state_q  <= S_RESP;
					end else begin
						target_q <= key_q;
						adv_q    <= 1'b0;
						addr_q   <= '0;
						pend_s1  <= 1'b0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (key_match) begin
						pend_s1 <= 1'b0;
						if (adv_q) begin
							target_q <= target_q + 32'd1;
							state_q  <= S_ADV;
						end else if (is_insert) begin
							status_q <= STAT_USED;
							state_q  <= S_RESP;
						end else begin
							status_q <= STAT_OK;
							vout_q   <= from_store(val_rdata);
							if (func_q == FN_REMOVE) begin
								addr_q  <= CNT_W'(pidx_s1) + CNT_W'(1);
								state_q <= S_SHIFT;
							end else begin
								state_q <= S_RESP;
							end
						end
					end else if (scan_miss) begin
						if (adv_q) begin
							next_id_q <= target_q;
							status_q  <= STAT_OK;
							state_q   <= S_RESP;
						end else if (is_insert) begin
							if (count_q >= CAP_CNT) begin
								status_q <= STAT_FULL;
								state_q  <= S_RESP;
							end else begin
								count_q  <= count_q + CNT_W'(1);
								target_q <= next_id_q;
								adv_q    <= 1'b1;
								state_q  <= S_ADV;
							end
						end else begin
							status_q <= STAT_MISSING;
							state_q  <= S_RESP;
						end
					end else begin
						pend_s1 <= issue;
						pidx_s1 <= addr_q[IDX_W-1:0];
						if (issue) begin
							addr_q <= addr_q + CNT_W'(1);
						end
					end
				end
				S_ADV: begin
					// Stop at all-ones; otherwise probe the candidate key.
					if (target_q == KEY_ONES) begin
						next_id_q <= target_q;
						status_q  <= STAT_OK;
						state_q   <= S_RESP;
					end else begin
						addr_q  <= '0;
						pend_s1 <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SHIFT: begin
					if (issue) begin
						pend_s1 <= 1'b1;
						pidx_s1 <= addr_dec[IDX_W-1:0];
						addr_q  <= addr_q + CNT_W'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q - CNT_W'(1);
							state_q <= S_RESP;
						end
					end
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
